// ----- src/erf_pkg.sv -----
// ============================================================================
// erf_pkg
// Shared types and constants for the escaped record framer.
// ============================================================================
`default_nettype none

package erf_pkg;

    localparam int DEFAULT_MAX_DATA_BYTES = 8;

    localparam logic [7:0]  OPEN_CODE_RESET   = 8'd126;
    localparam logic [7:0]  ESC_CODE_RESET    = 8'd125;
    localparam logic [7:0]  ESC_MASK_RESET    = 8'd32;
    localparam logic [15:0] BUFFER_SIZE_RESET = 16'd4096;

    localparam logic [3:0]  LAST_VALID_TYPE = 4'd8;
    localparam int          HEADER_BYTES    = 6;

    localparam logic [1:0] REG_OPEN_CODE   = 2'd0;
    localparam logic [1:0] REG_ESC_CODE    = 2'd1;
    localparam logic [1:0] REG_ESC_MASK    = 2'd2;
    localparam logic [1:0] REG_BUFFER_SIZE = 2'd3;

    localparam logic [0:0] OP_RECORD = 1'b0;
    localparam logic [0:0] OP_CLEAR  = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_BAD_TYPE = 2'd2;
    localparam logic [1:0] STATUS_CLEARED  = 2'd3;

    typedef struct packed {
        logic [0:0]  operation;
        logic [31:0] timestamp;
        logic [15:0] identifier;
        logic [63:0] data_value;
        logic [3:0]  data_size;
        logic [3:0]  value_type;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_last;
        logic [1:0] status;
    } out_t;

    typedef struct packed {
        logic [7:0] byte_val;
        logic [7:0] raw_val;
        logic       advance;
        logic       final_byte;
    } unit_t;

endpackage

`default_nettype wire

// ----- src/erf_byte_unit.sv -----
// ============================================================================
// erf_byte_unit
// Shared byte unit: picks the current raw frame byte and applies stuffing.
// ============================================================================
`default_nettype none

module erf_byte_unit
    import erf_pkg::*;
#(
    parameter int MAX_DATA_BYTES = DEFAULT_MAX_DATA_BYTES,
    localparam int IDX_W = $clog2(HEADER_BYTES + MAX_DATA_BYTES + 1)
)
(
    input  wire in_t              rec,
    input  wire logic [IDX_W-1:0] idx,
    input  wire logic [IDX_W-1:0] last_idx,
    input  wire logic [3:0]       size,
    input  wire logic [7:0]       sum,
    input  wire logic             esc_pending,
    input  wire logic [7:0]       open_code,
    input  wire logic [7:0]       esc_code,
    input  wire logic [7:0]       esc_mask,
    output unit_t                 res
);

    logic [IDX_W-1:0] vsel_full;
    logic [2:0]       vsel;
    logic [7:0]       raw;
    logic             is_ctrl;

    assign vsel_full = IDX_W'(size) + IDX_W'(HEADER_BYTES - 1) - idx;
    assign vsel      = vsel_full[2:0];

    always_comb
    begin
        if (idx == last_idx)
        begin
            raw = sum;
        end
        else
        begin
            case (idx)
                IDX_W'(0): raw = rec.timestamp[31:24];
                IDX_W'(1): raw = rec.timestamp[23:16];
                IDX_W'(2): raw = rec.timestamp[15:8];
                IDX_W'(3): raw = rec.timestamp[7:0];
                IDX_W'(4): raw = rec.identifier[15:8];
                IDX_W'(5): raw = rec.identifier[7:0];
                default:   raw = rec.data_value[{vsel, 3'b000} +: 8];
            endcase
        end
    end

    assign is_ctrl = (raw == open_code) || (raw == esc_code);

    always_comb
    begin
        res.raw_val = raw;
        if (esc_pending)
        begin
            res.byte_val = raw ^ esc_mask;
            res.advance  = 1'b1;
        end
        else if (is_ctrl)
        begin
            res.byte_val = esc_code;
            res.advance  = 1'b0;
        end
        else
        begin
            res.byte_val = raw;
            res.advance  = 1'b1;
        end
        res.final_byte = res.advance && (idx == last_idx);
    end

endmodule

`default_nettype wire

// ----- src/escaped_record_framer.sv -----
// ============================================================================
// escaped_record_framer
// Frames records into a byte-stuffed stream with an additive checksum.
// ============================================================================
//
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    in_data  (in_t)
// out      output     out_valid / out_stall  out_data (out_t)
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request is accepted and goes through the space and type check; a record then
// moves through the shared byte unit at one output byte per cycle unless the
// output stalls, while a clear, full or bad-type result gives one status byte.
// Output stalls hold the sequencer in place. in_stall is high while a request
// is in work. Reset is asynchronous, active low, and restores the register
// defaults and a zero fill level.
`default_nettype none

module escaped_record_framer
    import erf_pkg::*;
#(
    parameter int MAX_DATA_BYTES = DEFAULT_MAX_DATA_BYTES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_t         in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_t             out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int IDX_W = $clog2(HEADER_BYTES + MAX_DATA_BYTES + 1);

    typedef enum logic [2:0] {
        IDLE,
        CHECK,
        SINGLE,
        START,
        DATA
    } state_t;

    state_t           state_reg, state_next;
    in_t              rec_reg, rec_next;
    logic [3:0]       size_reg, size_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       sum_reg, sum_next;
    logic             esc_reg, esc_next;
    logic [1:0]       status_reg, status_next;
    logic [15:0]      fill_reg, fill_next;
    logic             out_valid_reg, out_valid_next;
    out_t             out_reg, out_next;
    logic [7:0]       start_reg, escape_reg, xor_reg;
    logic [15:0]      bsize_reg;

    logic             out_free;
    logic [IDX_W-1:0] last_idx;
    logic [5:0]       need;
    logic [16:0]      fill_plus_need;
    logic             full;
    unit_t            unit;

    assign in_stall  = (state_reg != IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    assign out_free       = !out_valid_reg || !out_stall;
    assign last_idx       = IDX_W'(HEADER_BYTES) + IDX_W'(size_reg);
    assign need           = 6'd16 + {1'b0, size_reg, 1'b0};
    assign fill_plus_need = {1'b0, fill_reg} + 17'(need);
    assign full           = fill_plus_need > {1'b0, bsize_reg};

    erf_byte_unit #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_byte_unit (
        .rec         (rec_reg),
        .idx         (idx_reg),
        .last_idx    (last_idx),
        .size        (size_reg),
        .sum         (sum_reg),
        .esc_pending (esc_reg),
        .open_code   (start_reg),
        .esc_code    (escape_reg),
        .esc_mask    (xor_reg),
        .res         (unit)
    );

    always_comb
    begin
        state_next     = state_reg;
        rec_next       = rec_reg;
        size_next      = size_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        esc_next       = esc_reg;
        status_next    = status_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;

        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    rec_next = in_data;
                    if (in_data.data_size > 4'(MAX_DATA_BYTES))
                    begin
                        size_next = 4'(MAX_DATA_BYTES);
                    end
                    else
                    begin
                        size_next = in_data.data_size;
                    end
                    state_next = CHECK;
                end
            end
            CHECK:
            begin
                idx_next = '0;
                esc_next = 1'b0;
                sum_next = start_reg;
                if (rec_reg.operation == OP_CLEAR)
                begin
                    fill_next   = '0;
                    status_next = STATUS_CLEARED;
                    state_next  = SINGLE;
                end
                else if (full)
                begin
                    status_next = STATUS_FULL;
                    state_next  = SINGLE;
                end
                else if (rec_reg.value_type > LAST_VALID_TYPE)
                begin
                    status_next = STATUS_BAD_TYPE;
                    state_next  = SINGLE;
                end
                else
                begin
                    state_next = START;
                end
            end
            SINGLE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_next.out_byte = '0;
                    out_next.is_last  = 1'b1;
                    out_next.status   = status_reg;
                    state_next        = IDLE;
                end
            end
            START:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_next.out_byte = start_reg;
                    out_next.is_last  = 1'b0;
                    out_next.status   = STATUS_OK;
                    fill_next         = fill_reg + 16'd1;
                    state_next        = DATA;
                end
            end
            DATA:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_next.out_byte = unit.byte_val;
                    out_next.is_last  = unit.final_byte;
                    out_next.status   = STATUS_OK;
                    fill_next         = fill_reg + 16'd1;
                    esc_next          = !unit.advance;
                    if (unit.advance)
                    begin
                        sum_next = sum_reg + unit.raw_val;
                        idx_next = idx_reg + IDX_W'(1);
                    end
                    if (unit.final_byte)
                    begin
                        state_next = IDLE;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            rec_reg       <= '0;
            size_reg      <= '0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            esc_reg       <= 1'b0;
            status_reg    <= STATUS_OK;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            start_reg     <= OPEN_CODE_RESET;
            escape_reg    <= ESC_CODE_RESET;
            xor_reg       <= ESC_MASK_RESET;
            bsize_reg     <= BUFFER_SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            rec_reg       <= rec_next;
            size_reg      <= size_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            esc_reg       <= esc_next;
            status_reg    <= status_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OPEN_CODE:   start_reg  <= cfg_data[7:0];
                    REG_ESC_CODE:    escape_reg <= cfg_data[7:0];
                    REG_ESC_MASK:    xor_reg    <= cfg_data[7:0];
                    REG_BUFFER_SIZE: bsize_reg  <= cfg_data;
                    default:         bsize_reg  <= bsize_reg;
                endcase
            end
        end
    end

endmodule

`default_nettype wire
